>>> rtl/fct_pkg.sv
// Shared types and constants of the frustum cull test block.
package fct_pkg;

  localparam int unsigned FracBits  = 14;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned HalfW     = 15;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned PlaneRegs = 6;
  localparam int unsigned ProdW     = 32;
  localparam int unsigned ReachProdW = 31;
  localparam int unsigned DistW     = 34;
  localparam int unsigned ReachW    = 32;
  localparam int unsigned SumW      = 36;
  localparam int unsigned InDataW   = 112;
  localparam int unsigned OutDataW  = 8;

  localparam logic CmdBox    = 1'b0;
  localparam logic CmdSphere = 1'b1;

  typedef struct packed {
    logic signed [15:0] d;
    logic signed [15:0] c;
    logic signed [15:0] b;
    logic signed [15:0] a;
  } plane_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } stage_en_t;

endpackage

>>> rtl/fct_cfg_regs.sv
// Plane configuration registers written through the configuration channel.
module fct_cfg_regs import fct_pkg::*; #(
  parameter int unsigned NumPlanes = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output plane_t              planes_o [NumPlanes]
);

  plane_t planes_q [NumPlanes];

  for (genvar i = 0; i < NumPlanes; i++) begin : g_plane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        planes_q[i] <= '0;
      end else if (cfg_valid_i && (cfg_index_i == CfgIdxW'(i))) begin
        planes_q[i] <= plane_t'(cfg_data_i);
      end
    end
    assign planes_o[i] = planes_q[i];
  end

endmodule

>>> rtl/fct_pipe_ctrl.sv
// Valid bits and stage enables of the three-stage test pipeline.
module fct_pipe_ctrl import fct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output stage_en_t en_o
);

  logic v1_q, v2_q, v3_q;
  logic ready1, ready2, ready3;

  assign ready3 = !v3_q || out_ready_i;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= in_valid_i;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  assign in_ready_o  = ready1;
  assign out_valid_o = v3_q;
  assign en_o.en1    = ready1;
  assign en_o.en2    = ready2;
  assign en_o.en3    = ready3;

endmodule

>>> rtl/fct_plane_eval.sv
// Products and sums of one plane; gives the plane's reject flag for stage three.
module fct_plane_eval import fct_pkg::*; (
  input  logic                     clk_i,
  input  plane_t                   plane_i,
  input  stage_en_t                en_i,
  input  logic signed [CoordW-1:0] cx_i,
  input  logic signed [CoordW-1:0] cy_i,
  input  logic signed [CoordW-1:0] cz_i,
  input  logic [HalfW-1:0]         hx_i,
  input  logic [HalfW-1:0]         hy_i,
  input  logic [HalfW-1:0]         hz_i,
  input  logic                     sphere_i,
  input  logic [HalfW-1:0]         radius_i,
  output logic                     reject_o
);

  logic [15:0] abs_a, abs_b, abs_c;
  logic signed [ProdW-1:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic [ReachProdW-1:0] rx_d, ry_d, rz_d, rx_q, ry_q, rz_q;
  logic signed [DistW-1:0] dist_d, dist_q;
  logic [ReachW-1:0] reach, add_d, add_q;
  logic signed [SumW-1:0] sum;

  assign abs_a = plane_i.a[15] ? (~plane_i.a + 16'd1) : plane_i.a;
  assign abs_b = plane_i.b[15] ? (~plane_i.b + 16'd1) : plane_i.b;
  assign abs_c = plane_i.c[15] ? (~plane_i.c + 16'd1) : plane_i.c;

  assign px_d = plane_i.a * cx_i;
  assign py_d = plane_i.b * cy_i;
  assign pz_d = plane_i.c * cz_i;
  assign rx_d = abs_a * hx_i;
  assign ry_d = abs_b * hy_i;
  assign rz_d = abs_c * hz_i;

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      rx_q <= rx_d;
      ry_q <= ry_d;
      rz_q <= rz_d;
    end
  end

  assign dist_d = DistW'(px_q) + DistW'(py_q) + DistW'(pz_q)
                + (DistW'(plane_i.d) <<< FracBits);
  assign reach  = ReachW'(rx_q) + ReachW'(ry_q) + ReachW'(rz_q);
  assign add_d  = (sphere_i == CmdSphere) ? ReachW'({radius_i, {FracBits{1'b0}}}) : reach;

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      dist_q <= dist_d;
      add_q  <= add_d;
    end
  end

  assign sum      = SumW'(dist_q) + $signed({{(SumW-ReachW){1'b0}}, add_q});
  assign reject_o = sum[SumW-1];

endmodule

>>> rtl/frustum_cull_test_top.sv
// Usage notes: a stream of bounding volumes enters on s_axis and one visible flag
// per beat leaves on m_axis. Slave tuser carries the volume kind (box or sphere),
// slave tdata carries center, half extents and radius; master tdata bit 0 is the
// visible flag. Plane registers are written through the cfg channel, which is
// always ready; write them only while no beat is in flight.
// An accepted beat passes registered stages of multipliers, of the plane sums,
// and of the final compare with the OR over all planes before its result leaves
// on m_axis. A new beat can enter every cycle while m_axis_tready does not hold
// the pipeline back, so the throughput is then one volume per clock.
// Reset clears all plane registers to zero, which makes every plane accept every
// volume, and empties the pipeline. When m_axis_tready is low the pipeline fills
// its empty stages and then holds s_axis_tready low; no beat is dropped.
module frustum_cull_test_top import fct_pkg::*; #(
  parameter int unsigned PLANE_COUNT = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0: center_x, center_y, center_z, half_x, half_y, half_z, radius.
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Fields from bit 0: cmd.
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // Fields from bit 0: visible.
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned NumActive = (PLANE_COUNT < PlaneRegs) ? PLANE_COUNT : PlaneRegs;

  plane_t    planes [NumActive];
  stage_en_t en;
  logic [NumActive-1:0] reject;
  logic sphere_q;
  logic [HalfW-1:0] radius_q;
  logic visible_q;

  logic signed [CoordW-1:0] cx, cy, cz;
  logic [HalfW-1:0] hx, hy, hz, rad;

  assign cx  = s_axis_tdata[15:0];
  assign cy  = s_axis_tdata[31:16];
  assign cz  = s_axis_tdata[47:32];
  assign hx  = s_axis_tdata[62:48];
  assign hy  = s_axis_tdata[77:63];
  assign hz  = s_axis_tdata[92:78];
  assign rad = s_axis_tdata[107:93];

  assign cfg_ready_o = 1'b1;

  fct_cfg_regs #(
    .NumPlanes(NumActive)
  ) u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .planes_o(planes)
  );

  fct_pipe_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .en_o       (en)
  );

  always_ff @(posedge clk_i) begin
    if (en.en1) begin
      sphere_q <= s_axis_tuser[0];
      radius_q <= rad;
    end
  end

  for (genvar i = 0; i < NumActive; i++) begin : g_plane
    fct_plane_eval u_eval (
      .clk_i,
      .plane_i (planes[i]),
      .en_i    (en),
      .cx_i    (cx),
      .cy_i    (cy),
      .cz_i    (cz),
      .hx_i    (hx),
      .hy_i    (hy),
      .hz_i    (hz),
      .sphere_i(sphere_q),
      .radius_i(radius_q),
      .reject_o(reject[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en.en3) begin
      visible_q <= ~|reject;
    end
  end

  assign m_axis_tdata = {{(OutDataW-1){1'b0}}, visible_q};

`ifndef SYNTHESIS
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
    else $error("Input stalled although the output side can move.");

  a_three_cycle_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid)
    else $error("Accepted beat did not reach the output after three cycles.");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (cfg_ready_o && ($past(s_axis_tready) || 1'b1)))
    else $error("Configuration channel not ready.");
`endif

endmodule

>>> tb/frustum_cull_test_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the six-plane frustum cull block.
module frustum_cull_test_top_test;
  import fct_pkg::*;

  localparam int unsigned NumPlanes   = 6;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned PhaseCount  = 10;
  localparam int unsigned PhaseItems  = 165;
  localparam int unsigned RegNear     = 0;
  localparam int unsigned RegFar      = 1;
  localparam int unsigned RegLeft     = 2;
  localparam int unsigned RegRight    = 3;
  localparam int unsigned RegTop      = 4;
  localparam int unsigned RegBottom   = 5;
  localparam int unsigned RegUnmapped = 6;
  localparam logic [15:0] UnitNormal  = 16'sd16384;

  class cull_scoreboard;
    plane_t      planes [PlaneRegs];
    bit          visible_q [$];
    int unsigned errors;

    function new();
      foreach (planes[i]) planes[i] = '0;
      errors = 0;
    endfunction

    function void load_plane(int unsigned idx, logic [CfgDataW-1:0] value);
      if (idx < PlaneRegs) planes[idx] = plane_t'(value);
    endfunction

    function bit volume_visible(logic cmd, logic [InDataW-1:0] vol);
      longint cx, cy, cz, hx, hy, hz, rad;
      longint a, b, c, d, distance, reach;
      bit     vis;
      int     i;
      cx  = longint'($signed(vol[15:0]));
      cy  = longint'($signed(vol[31:16]));
      cz  = longint'($signed(vol[47:32]));
      hx  = longint'(vol[62:48]);
      hy  = longint'(vol[77:63]);
      hz  = longint'(vol[92:78]);
      rad = longint'(vol[107:93]);
      vis = 1'b1;
      for (i = 0; i < NumPlanes && i < PlaneRegs; i++) begin
        a = longint'($signed(planes[i].a));
        b = longint'($signed(planes[i].b));
        c = longint'($signed(planes[i].c));
        d = longint'($signed(planes[i].d));
        distance = a * cx + b * cy + c * cz + (d <<< FracBits);
        if (cmd == CmdSphere) begin
          if (distance < -(rad <<< FracBits)) vis = 1'b0;
        end else begin
          reach = (a < 0 ? -a : a) * hx + (b < 0 ? -b : b) * hy + (c < 0 ? -c : c) * hz;
          if (distance + reach < 0) vis = 1'b0;
        end
      end
      return vis;
    endfunction

    function void note_volume(logic cmd, logic [InDataW-1:0] vol);
      visible_q.push_back(volume_visible(cmd, vol));
    endfunction

    function int unsigned pending();
      return visible_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [OutDataW-1:0] beat);
      bit want;
      if (visible_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0h with no volume pending", beat));
        return;
      end
      want = visible_q.pop_front();
      if (beat[0] !== want)
        report_mismatch($sformatf("visible got %b expected %b", beat[0], want));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [0:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bit              src_gaps;
  bit              snk_gaps;
  int unsigned     idle_cycles = 0;
  cull_scoreboard  sb = new();

  frustum_cull_test_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [InDataW-1:0] pack_volume(logic [15:0] cx, logic [15:0] cy,
                                                     logic [15:0] cz, logic [14:0] hx,
                                                     logic [14:0] hy, logic [14:0] hz,
                                                     logic [14:0] rad);
    return {4'b0, rad, hz, hy, hx, cz, cy, cx};
  endfunction

  function automatic logic [CfgDataW-1:0] make_plane(logic [15:0] a, logic [15:0] b,
                                                     logic [15:0] c, logic [15:0] d);
    return {d, c, b, a};
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return ($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF) ^
                      ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      1, 2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 4095)) - 16'd2048;
    endcase
  endfunction

  function automatic logic [14:0] rand_half();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
      1, 2:    return 15'($urandom);
      default: return 15'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_volume(logic cmd, logic [InDataW-1:0] vol);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 14) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= vol;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(int unsigned idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgIdxW'(idx);
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.load_plane(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // An axis-aligned box frustum: each plane keeps points on its inner side.
  task automatic load_frustum(logic [15:0] n, logic [15:0] ext);
    settle();
    write_reg(RegNear,   make_plane(16'd0, 16'd0, n, ext));
    write_reg(RegFar,    make_plane(16'd0, 16'd0, -n, ext));
    write_reg(RegLeft,   make_plane(n, 16'd0, 16'd0, ext));
    write_reg(RegRight,  make_plane(-n, 16'd0, 16'd0, ext));
    write_reg(RegTop,    make_plane(16'd0, -n, 16'd0, ext));
    write_reg(RegBottom, make_plane(16'd0, n, 16'd0, ext));
  endtask

  task automatic load_all(logic [CfgDataW-1:0] value);
    settle();
    for (int unsigned i = 0; i < PlaneRegs; i++) write_reg(i, value);
  endtask

  task automatic load_random_planes();
    settle();
    for (int unsigned i = 0; i < PlaneRegs; i++)
      write_reg(i, ($urandom_range(0, 2) == 0) ? 64'd0 : {$urandom, $urandom});
    write_reg(RegUnmapped + $urandom_range(0, 1), {$urandom, $urandom});
  endtask

  task automatic send_random_volume();
    send_volume($urandom_range(0, 1) ? CmdSphere : CmdBox,
                pack_volume(rand_coord(), rand_coord(), rand_coord(), rand_half(),
                            rand_half(), rand_half(), rand_half()));
  endtask

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned stall;
      stall = snk_gaps ? $urandom_range(0, 14) : 0;
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_volume(s_axis_tuser[0], s_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    src_gaps      = 1'b0;
    snk_gaps      = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Planes still hold their reset value of zero, so nothing is rejected.
    send_volume(CmdBox, pack_volume(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF,
                                    15'h7FFF, 15'h7FFF));
    send_volume(CmdSphere, pack_volume(16'h8000, 16'h8000, 16'h8000, 15'h5555, 15'h2AAA,
                                       15'h7FFF, 15'h7FFF));
    send_volume(CmdBox, pack_volume(16'h8000, 16'h7FFF, 16'h8000, 15'h0, 15'h0, 15'h0,
                                    15'h0));

    // Cube of half size 1000; writes past the last plane must change nothing.
    load_frustum(UnitNormal, 16'd1000);
    write_reg(RegUnmapped, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegUnmapped + 1, 64'h8000_8000_8000_8000);
    send_volume(CmdBox, pack_volume(16'd0, 16'd0, 16'd0, 15'd0, 15'd0, 15'd0, 15'd0));
    send_volume(CmdBox, pack_volume(16'd5000, 16'd0, 16'd0, 15'd0, 15'd0, 15'd0, 15'd0));
    send_volume(CmdBox, pack_volume(16'd5000, 16'd0, 16'd0, 15'd4000, 15'd0, 15'd0,
                                    15'd0));
    send_volume(CmdBox, pack_volume(16'd5000, 16'd0, 16'd0, 15'd3999, 15'd0, 15'd0,
                                    15'h7FFF));
    send_volume(CmdBox, pack_volume(-16'sd5000, 16'd0, 16'd0, 15'd4000, 15'd0, 15'd0,
                                    15'd0));
    send_volume(CmdSphere, pack_volume(16'd0, 16'd0, 16'd1500, 15'd0, 15'd0, 15'd0,
                                       15'd500));
    send_volume(CmdSphere, pack_volume(16'd0, 16'd0, 16'd1500, 15'h7FFF, 15'h7FFF,
                                       15'h7FFF, 15'd499));
    send_volume(CmdSphere, pack_volume(16'd0, -16'sd1500, 16'd0, 15'h7FFF, 15'd3,
                                       15'd9, 15'd500));
    send_volume(CmdBox, pack_volume(16'd0, 16'd0, -16'sd1001, 15'd0, 15'd0, 15'd0,
                                    15'h7FFF));
    send_volume(CmdBox, pack_volume(16'd0, 16'd0, -16'sd1001, 15'd0, 15'd0, 15'd1,
                                    15'd0));
    send_volume(CmdSphere, pack_volume(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'd0, 15'd0,
                                       15'd0, 15'd0));
    send_volume(CmdBox, pack_volume(16'h8000, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF,
                                    15'h7FFF, 15'd0));

    // Most negative normals and offset on every plane.
    load_all(make_plane(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_volume(CmdBox, pack_volume(16'h8000, 16'h8000, 16'h8000, 15'd0, 15'd0, 15'd0,
                                    15'd0));
    send_volume(CmdSphere, pack_volume(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'd0, 15'd0,
                                       15'd0, 15'h7FFF));
    send_volume(CmdBox, pack_volume(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF,
                                    15'h7FFF, 15'd0));

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      case (p)
        2:       load_all(64'hFFFF_FFFF_FFFF_FFFF);
        3: begin
          settle();
          for (int unsigned i = 0; i < PlaneRegs; i++)
            write_reg(i, i[0] ? make_plane(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000)
                              : make_plane(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        end
        default: begin
          if (p[0]) load_random_planes();
          else load_frustum(16'($urandom_range(1, 32767)), 16'($urandom_range(0, 2047)));
        end
      endcase
      src_gaps = (p % 3) != 2;
      snk_gaps = (p % 3) != 1;
      repeat (PhaseItems) send_random_volume();
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
